// File: rtl/dll_pkg.sv
// Package for the doubly linked list engine: constants, command and status codes,
// and the command and result word types. No dependencies.
package dll_pkg;

  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefDataWidth = 32;

  typedef enum logic [2:0] {
    CMD_FRONT  = 3'd0,
    CMD_BACK   = 3'd1,
    CMD_BEFORE = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               reverse_pass;
    logic               last;
  } res_t;

endpackage

// File: rtl/doubly_linked_list_engine_unit.sv
// Doubly linked list engine top level: sequencer, node memories, free map.
// Depends on dll_pkg.
//
// One command is taken when start_i is high and busy_o is low; busy_o then
// stays high until the cycle in which the command's last result word is
// shown. Every result word is on res_o for exactly one cycle with
// res_valid_o high, and the receiver cannot hold it off. How long a command
// runs is set by the walk over linked nodes: each node is read in S_RD,
// which issues the address, and looked at in S_CHK on the registered read
// data. An insert at front or back walks no nodes, a key search walks at
// most CAPACITY nodes, and a read-out walks the list forward, then backward,
// one result word per node. No clearing pass: nodes are only read once linked.
module doubly_linked_list_engine_unit
  import dll_pkg::*;
#(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned IW = $clog2(CAPACITY + 1); // index incl. null
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] Nil = IW'(CAPACITY);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_DISP   = 8'b00000010,
    S_RD     = 8'b00000100, // address issued, wait for data
    S_CHK    = 8'b00001000, // look at node data
    S_LINK1  = 8'b00010000,
    S_LINK2  = 8'b00100000,
    S_EMIT   = 8'b01000000,
    S_LINK0  = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // node memories
  logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
  logic [IW-1:0]         nxt_mem [CAPACITY];
  logic [IW-1:0]         prv_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_val_q;
  logic [IW-1:0]         rd_nxt_q, rd_prv_q;

  logic [IW-1:0]   head_q, tail_q, cur_q, newn_q, bef_q;
  logic [IW-1:0]   cnt_q;
  logic [CAPACITY-1:0] free_q;
  logic [IW-1:0]   steps_q;
  logic            rev_q;
  cmd_t            cmd_q;

  logic [DATA_WIDTH-1:0] val_in, key_in;
  assign val_in = DATA_WIDTH'({{32{cmd_q.value[31]}}, cmd_q.value});
  assign key_in = DATA_WIDTH'({{32{cmd_q.key[31]}}, cmd_q.key});

  // first free node
  logic [IW-1:0] grab;
  always_comb begin
    grab = Nil;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) grab = IW'(i);
    end
  end

  logic full;
  assign full = (free_q == '0);

  logic [31:0] out_val;
  assign out_val = 32'($signed(rd_val_q));

  // memory write port and read port control
  logic          we_v, we_n, we_p;
  logic [AW-1:0] wa_v, wa_n, wa_p;
  logic [IW-1:0] wd_n, wd_p;
  logic          re;
  logic [AW-1:0] ra;

  always_ff @(posedge clk_i) begin
    if (we_v) val_mem[wa_v] <= val_in;
    if (we_n) nxt_mem[wa_n] <= wd_n;
    if (we_p) prv_mem[wa_p] <= wd_p;
    if (re) begin
      rd_val_q <= val_mem[ra];
      rd_nxt_q <= nxt_mem[ra];
      rd_prv_q <= prv_mem[ra];
    end
  end

  // sequencer
  logic [IW-1:0] head_d, tail_d, cur_d, newn_d, bef_d, cnt_d, steps_d;
  logic [CAPACITY-1:0] free_d;
  logic rev_d;
  res_t res_d;
  logic rv_d;

  always_comb begin
    state_d = state_q;
    head_d = head_q; tail_d = tail_q; cur_d = cur_q; newn_d = newn_q;
    bef_d = bef_q; cnt_d = cnt_q; free_d = free_q; steps_d = steps_q;
    rev_d = rev_q;
    we_v = 1'b0; we_n = 1'b0; we_p = 1'b0;
    wa_v = '0; wa_n = '0; wa_p = '0; wd_n = '0; wd_p = '0;
    re = 1'b0; ra = AW'(cur_q);
    rv_d = 1'b0;
    res_d = '{status: ST_OK, read_value: '0, reverse_pass: 1'b0, last: 1'b1};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DISP;
      end
      S_DISP: begin
        cur_d = head_q; steps_d = '0; rev_d = 1'b0;
        state_d = S_IDLE;
        rv_d = 1'b1;
        unique case (cmd_q.command)
          CMD_FRONT, CMD_BACK: begin
            if (full) res_d.status = ST_FULL;
            else begin
              rv_d = 1'b0;
              cur_d = (cmd_q.command == CMD_FRONT) ? head_q : Nil;
              bef_d = (cmd_q.command == CMD_FRONT) ? Nil : tail_q;
              state_d = S_LINK0;
            end
          end
          CMD_BEFORE, CMD_DELETE: begin
            if (cnt_q == '0) res_d.status = ST_EMPTY;
            else if (cmd_q.command == CMD_BEFORE && full) res_d.status = ST_FULL;
            else begin rv_d = 1'b0; state_d = S_RD; end
          end
          CMD_READ: begin
            if (cnt_q == '0 || head_q == Nil) res_d.status = ST_EMPTY;
            else begin rv_d = 1'b0; state_d = S_RD; end
          end
          default: ;
        endcase
      end
      S_RD: begin
        re = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (cmd_q.command == CMD_READ) begin
          rv_d = 1'b1;
          res_d.read_value = out_val;
          res_d.reverse_pass = rev_q;
          res_d.last = 1'b0;
          cur_d = rev_q ? rd_prv_q : rd_nxt_q;
          steps_d = steps_q + 1'b1;
          state_d = S_RD;
          if (cur_d == Nil || steps_d == IW'(CAPACITY)) begin
            if (rev_q) begin
              res_d.last = 1'b1;
              state_d = S_IDLE;
            end else begin
              rev_d = 1'b1; cur_d = tail_q; steps_d = '0;
            end
          end
        end else if (rd_val_q == key_in) begin
          bef_d = rd_prv_q;
          if (cmd_q.command == CMD_DELETE) state_d = S_LINK1;
          else state_d = S_LINK0;
        end else begin
          cur_d = rd_nxt_q;
          steps_d = steps_q + 1'b1;
          state_d = S_RD;
          if (cur_d == Nil || steps_d == IW'(CAPACITY)) begin
            rv_d = 1'b1; res_d.status = ST_NOT_FOUND; state_d = S_IDLE;
          end
        end
      end
      S_LINK0: begin
        // insert: new node between bef_q and cur_q
        newn_d = grab;
        free_d[AW'(grab)] = 1'b0;
        we_v = 1'b1; wa_v = AW'(grab);
        we_n = 1'b1; wa_n = AW'(grab); wd_n = cur_q;
        we_p = 1'b1; wa_p = AW'(grab); wd_p = bef_q;
        cnt_d = cnt_q + 1'b1;
        state_d = S_LINK1;
      end
      S_LINK1: begin
        if (cmd_q.command == CMD_DELETE) begin
          // bef_q.next = rd_nxt_q
          if (bef_q != Nil) begin we_n = 1'b1; wa_n = AW'(bef_q); wd_n = rd_nxt_q; end
          else head_d = rd_nxt_q;
          if (rd_nxt_q != Nil) begin we_p = 1'b1; wa_p = AW'(rd_nxt_q); wd_p = bef_q; end
          else tail_d = bef_q;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
          free_d[AW'(cur_q)] = 1'b1;
        end else begin
          if (bef_q != Nil) begin we_n = 1'b1; wa_n = AW'(bef_q); wd_n = newn_q; end
          else head_d = newn_q;
          if (cur_q != Nil) begin we_p = 1'b1; wa_p = AW'(cur_q); wd_p = newn_q; end
          else tail_d = newn_q;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        rv_d = 1'b1;
        state_d = S_IDLE;
      end
      S_LINK2: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= Nil; tail_q <= Nil; cnt_q <= '0; free_q <= '1;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d; tail_q <= tail_d; cnt_q <= cnt_d; free_q <= free_d;
      res_valid_o <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) cmd_q <= cmd_i;
    cur_q <= cur_d; newn_q <= newn_d; bef_q <= bef_d;
    steps_q <= steps_d; rev_q <= rev_d;
    res_o <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for doubly_linked_list_engine_unit: directed table, then random commands,
// every result word checked against an in-bench list predictor. Depends on dll_pkg.
module tb;
  import dll_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam int unsigned WatchLimit = 4000;

  logic clk_i, rst_ni, start_i, busy_o, res_valid_o;
  cmd_t cmd_i;
  res_t res_o;

  doubly_linked_list_engine_unit u_dut (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .res_valid_o, .res_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: the list kept as a plain queue of values, head first
  logic signed [31:0] list_q[$];
  res_t expected_words[$];
  int unsigned fail_count;
  int unsigned idle_count;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  function automatic res_t mk(input status_e st, input logic signed [31:0] v,
                              input logic rev, input logic fin);
    res_t r;
    r.status = st;
    r.read_value = v;
    r.reverse_pass = rev;
    r.last = fin;
    return r;
  endfunction

  // work out the result words of one command and update the list
  task automatic predict_list_cmd(input cmd_t c);
    int pos;
    pos = -1;
    case (c.command)
      CMD_FRONT, CMD_BACK: begin
        if (list_q.size() == Cap) expected_words.push_back(mk(ST_FULL, 0, 0, 1));
        else begin
          if (c.command == CMD_FRONT) list_q.push_front(c.value);
          else list_q.push_back(c.value);
          expected_words.push_back(mk(ST_OK, 0, 0, 1));
        end
      end
      CMD_BEFORE: begin
        for (int i = list_q.size() - 1; i >= 0; i--) if (list_q[i] == c.key) pos = i;
        if (list_q.size() == 0) expected_words.push_back(mk(ST_EMPTY, 0, 0, 1));
        else if (list_q.size() == Cap) expected_words.push_back(mk(ST_FULL, 0, 0, 1));
        else if (pos < 0) expected_words.push_back(mk(ST_NOT_FOUND, 0, 0, 1));
        else begin
          list_q.insert(pos, c.value);
          expected_words.push_back(mk(ST_OK, 0, 0, 1));
        end
      end
      CMD_DELETE: begin
        for (int i = list_q.size() - 1; i >= 0; i--) if (list_q[i] == c.key) pos = i;
        if (list_q.size() == 0) expected_words.push_back(mk(ST_EMPTY, 0, 0, 1));
        else if (pos < 0) expected_words.push_back(mk(ST_NOT_FOUND, 0, 0, 1));
        else begin
          list_q.delete(pos);
          expected_words.push_back(mk(ST_OK, 0, 0, 1));
        end
      end
      CMD_READ: begin
        if (list_q.size() == 0) expected_words.push_back(mk(ST_EMPTY, 0, 0, 1));
        else begin
          foreach (list_q[i]) expected_words.push_back(mk(ST_OK, list_q[i], 0, 0));
          for (int i = list_q.size() - 1; i >= 0; i--)
            expected_words.push_back(mk(ST_OK, list_q[i], 1, i == 0));
        end
      end
      default: expected_words.push_back(mk(ST_OK, 0, 0, 1));
    endcase
  endtask

  // result checker; the receiver cannot stall, so every strobe is a word
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_words.size() == 0) report_mismatch("result word with none expected");
      else begin
        res_t e;
        e = expected_words.pop_front();
        if (res_o.status !== e.status)
          report_mismatch($sformatf("status %0d, wanted %0d", res_o.status, e.status));
        if (res_o.read_value !== e.read_value)
          report_mismatch($sformatf("read_value %0d, wanted %0d",
                                    res_o.read_value, e.read_value));
        if (res_o.reverse_pass !== e.reverse_pass)
          report_mismatch($sformatf("reverse_pass %0b, wanted %0b",
                                    res_o.reverse_pass, e.reverse_pass));
        if (res_o.last !== e.last)
          report_mismatch($sformatf("last %0b, wanted %0b", res_o.last, e.last));
      end
    end
  end

  // watchdog: cycles with neither a command nor a result word accepted
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // directed table; typed-in checks only for plain error codes
  typedef struct {
    cmd_t c;
    logic typed;
    status_e st;
  } row_t;
  row_t table_rows[$];

  task automatic add_row(input logic [2:0] op, input logic signed [31:0] v,
                         input logic signed [31:0] k, input logic typed, input status_e st);
    row_t r;
    r.c.command = op;
    r.c.value = v;
    r.c.key = k;
    r.typed = typed;
    r.st = st;
    table_rows.push_back(r);
  endtask

  // one command word; a gap comes before about 19 commands in a hundred unless quiet.
  // start_i stays high from one word to the next when there is no gap.
  task automatic send_cmd(input cmd_t c, input bit quiet);
    if (!quiet && $urandom_range(99) < 19) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 19);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_list_cmd(c);
  endtask

  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return $signed($urandom_range(7)) - 3;
    endcase
  endfunction

  initial begin
    cmd_t c;
    row_t r;
    start_i = 1'b0;
    cmd_i = '0;
    rst_ni = 1'b0;
    fail_count = 0;
    idle_count = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(CMD_READ, 0, 0, 1, ST_EMPTY);
    add_row(CMD_DELETE, 0, 0, 1, ST_EMPTY);
    add_row(CMD_BEFORE, 1, 0, 1, ST_EMPTY);
    add_row(CMD_FRONT, 32'sh7fffffff, 0, 0, ST_OK);
    add_row(CMD_DELETE, 0, 32'sh7fffffff, 0, ST_OK);  // sole node deleted
    add_row(CMD_READ, 0, 0, 1, ST_EMPTY);
    add_row(CMD_BACK, 32'sh80000000, 0, 0, ST_OK);
    add_row(CMD_BEFORE, 5, 32'sh80000000, 0, ST_OK);  // before the head
    add_row(CMD_BEFORE, 6, 99, 1, ST_NOT_FOUND);
    add_row(CMD_DELETE, 0, 99, 1, ST_NOT_FOUND);
    add_row(CMD_READ, 0, 0, 0, ST_OK);
    add_row(3'd5, -1, -1, 0, ST_OK);
    add_row(3'd7, 0, 0, 0, ST_OK);
    for (int i = 0; i < 14; i++) add_row(CMD_BACK, -1 - i, 0, 0, ST_OK);
    add_row(CMD_FRONT, 1, 0, 1, ST_FULL);
    add_row(CMD_BACK, 1, 0, 1, ST_FULL);
    add_row(CMD_BEFORE, 1, 5, 1, ST_FULL);
    add_row(CMD_READ, 0, 0, 0, ST_OK);

    foreach (table_rows[i]) begin
      r = table_rows[i];
      if (r.typed) begin
        // pin the plain error code by hand as well as through the predictor
        predict_list_cmd(r.c);
        if (expected_words[$].status != r.st) report_mismatch("table status");
        void'(expected_words.pop_back());
        r.c = r.c;
      end
      send_cmd(r.c, 1'b0);
    end
    // drain the full list so random traffic starts near empty
    for (int i = 0; i < 16; i++) begin
      c.command = CMD_DELETE;
      c.value = 0;
      c.key = list_q.size() ? list_q[0] : 0;
      send_cmd(c, 1'b0);
    end

    for (int n = 0; n < 100; n++) begin
      int sel;
      sel = $urandom_range(99);
      c.value = ($urandom_range(3) == 0) ? $signed($urandom()) : pick_val();
      c.key = (list_q.size() && $urandom_range(3) != 0) ?
              list_q[$urandom_range(list_q.size() - 1)] : pick_val();
      if ($urandom_range(9) == 0) c.key = $signed($urandom());
      if (sel < 25) c.command = CMD_FRONT;
      else if (sel < 45) c.command = CMD_BACK;
      else if (sel < 62) c.command = CMD_BEFORE;
      else if (sel < 85) c.command = CMD_DELETE;
      else if (sel < 97) c.command = CMD_READ;
      else c.command = 3'($urandom_range(7, 5));
      send_cmd(c, n >= 40 && n < 75);  // a quiet stretch in the middle
    end
    start_i <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: doubly_linked_list_engine_unit.f
rtl/dll_pkg.sv
rtl/doubly_linked_list_engine_unit.sv
tb/sv/tb.sv
